/* design/c2dp_pkg.sv */
// Shared types and constants for the complex-to-display-pixel block.
// No dependencies; imported by every module of the block.
package c2dp_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS    = 16;
    localparam int GAIN_FRAC    = 16;
    localparam int PHASE_BITS   = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 32;

    // Right shifts that bring each product back to pixel units
    localparam int SH_SQ  = 2 * FRAC_BITS + GAIN_FRAC;
    localparam int SH_LIN = FRAC_BITS + GAIN_FRAC;
    localparam int SH_PH  = PHASE_BITS + GAIN_FRAC;

    // Largest frame dimension; larger size registers are clamped to it
    localparam logic [12:0] MAX_DIM = 13'd4096;

    // Register stages from the input register to the pixel register
    localparam int PIPE_DEPTH = 38;

    // Display modes
    localparam logic [2:0] MODE_SQ    = 3'd0;
    localparam logic [2:0] MODE_MAG   = 3'd1;
    localparam logic [2:0] MODE_RE    = 3'd2;
    localparam logic [2:0] MODE_IM    = 3'd3;
    localparam logic [2:0] MODE_PHASE = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_SHIFT  = 3'd1;
    localparam logic [2:0] CFG_GAIN   = 3'd2;
    localparam logic [2:0] CFG_ROWS   = 3'd3;
    localparam logic [2:0] CFG_COLS   = 3'd4;

    typedef struct packed {
        logic signed [31:0] real_part;
        logic signed [31:0] imag_part;
        logic [11:0]        in_row;
        logic [11:0]        in_col;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [11:0] out_row;
        logic [11:0] out_col;
    } out_item_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] turn_step(input int i);
        logic [31:0] t;
        case (i)
            0:  t = 32'h2000_0000;
            1:  t = 32'h12E4_051E;
            2:  t = 32'h09FB_385B;
            3:  t = 32'h0511_11D4;
            4:  t = 32'h028B_0D43;
            5:  t = 32'h0145_D7E1;
            6:  t = 32'h00A2_F61E;
            7:  t = 32'h0051_7C55;
            8:  t = 32'h0028_BE53;
            9:  t = 32'h0014_5F2F;
            10: t = 32'h000A_2F98;
            11: t = 32'h0005_17CC;
            12: t = 32'h0002_8BE6;
            13: t = 32'h0001_45F3;
            14: t = 32'h0000_A2FA;
            15: t = 32'h0000_517D;
            16: t = 32'h0000_28BE;
            17: t = 32'h0000_145F;
            18: t = 32'h0000_0A30;
            19: t = 32'h0000_0518;
            20: t = 32'h0000_028C;
            21: t = 32'h0000_0146;
            22: t = 32'h0000_00A3;
            23: t = 32'h0000_0051;
            24: t = 32'h0000_0029;
            25: t = 32'h0000_0014;
            26: t = 32'h0000_000A;
            27: t = 32'h0000_0005;
            28: t = 32'h0000_0003;
            29: t = 32'h0000_0001;
            default: t = 32'h0000_0000;
        endcase
        return t;
    endfunction

    // Half-frame swap of one index
    function automatic logic [11:0] place(input logic [11:0] idx, input logic [12:0] size,
                                          input logic swap);
        logic [12:0] n;
        logic [11:0] half;
        n    = (size > MAX_DIM) ? MAX_DIM : size;
        half = n[12:1];
        if (!swap)
            return idx;
        else if (idx < half)
            return idx + half;
        else
            return idx - half;
    endfunction

endpackage

/* design/c2dp_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on c2dp_pkg.
module c2dp_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] value,
    output logic [31:0] root
);
    import c2dp_pkg::*;

    logic [63:0] rem_reg  [SQRT_STEPS-1];
    logic [63:0] root_reg [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        localparam logic [63:0] ONE = 64'd1 << (62 - 2 * j);
        logic [63:0] rem_in;
        logic [63:0] root_in;
        logic [63:0] trial;
        logic        take;

        if (j == 0) begin : g_first
            assign rem_in  = value;
            assign root_in = '0;
        end
        else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        assign trial = root_in + ONE;
        assign take  = (rem_in >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[j] <= take ? ((root_in >> 1) + ONE) : (root_in >> 1);
            end
        end

        // last step needs no remainder
        if (j < SQRT_STEPS - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= take ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1][31:0];

endmodule

/* design/c2dp_cordic.sv */
// Pipelined vectoring CORDIC: phase magnitude in units of 2^-32 turn.
// Depends on c2dp_pkg (step table, step count).
module c2dp_cordic (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] re,
    input  logic signed [31:0] im,
    output logic [31:0]        phase_mag
);
    import c2dp_pkg::*;

    logic signed [63:0] x_reg    [CORDIC_STEPS+1];
    logic signed [63:0] y_reg    [CORDIC_STEPS+1];
    logic [31:0]        ang_reg  [CORDIC_STEPS+1];
    logic               zero_reg [CORDIC_STEPS+1];
    logic [31:0]        mag_reg;

    logic signed [63:0] re_w;
    logic signed [63:0] im_w;
    logic [31:0]        ang_fin;

    assign re_w = 64'(re);
    assign im_w = 64'(im);

    // fold left half-plane onto the right, half a turn preloaded
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= (re[31] ? -re_w : re_w) <<< 30;
            y_reg[0]    <= (re[31] ? -im_w : im_w) <<< 30;
            ang_reg[0]  <= re[31] ? 32'h8000_0000 : 32'h0000_0000;
            zero_reg[0] <= (re == 32'sd0) && (im == 32'sd0);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][63])
                begin
                    x_reg[i+1]   <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] - (x_reg[i] >>> i);
                    ang_reg[i+1] <= ang_reg[i] + turn_step(i);
                end
                else
                begin
                    x_reg[i+1]   <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] + (x_reg[i] >>> i);
                    ang_reg[i+1] <= ang_reg[i] - turn_step(i);
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign ang_fin = ang_reg[CORDIC_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[CORDIC_STEPS])
                mag_reg <= '0;
            else
                mag_reg <= ang_fin[31] ? (~ang_fin + 32'd1) : ang_fin;
        end
    end

    assign phase_mag = mag_reg;

endmodule

/* design/c2dp_scale.sv */
// Gain scaling and 8-bit saturation: 64x32 product in two halves, then shift.
// Depends on c2dp_pkg (mode codes, shift amounts).
module c2dp_scale (
    input  logic        clk,
    input  logic        en,
    input  logic [2:0]  mode,
    input  logic [23:0] gain,
    input  logic [63:0] mag,
    output logic [7:0]  pixel
);
    import c2dp_pkg::*;

    logic [31:0] k_reg;
    logic [63:0] p_lo_reg;
    logic [63:0] p_hi_reg;
    logic [95:0] prod_reg;
    logic [7:0]  pixel_reg;
    logic [95:0] shifted;

    // 255 * gain, follows the gain register
    always_ff @(posedge clk)
    begin
        k_reg <= {gain, 8'd0} - {8'd0, gain};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg <= 64'(mag[31:0]) * 64'(k_reg);
            p_hi_reg <= 64'(mag[63:32]) * 64'(k_reg);
            prod_reg <= {p_hi_reg, 32'd0} + {32'd0, p_lo_reg};
            pixel_reg <= (|shifted[95:8]) ? 8'hFF : shifted[7:0];
        end
    end

    always_comb
    begin
        case (mode)
            MODE_SQ:    shifted = prod_reg >> SH_SQ;
            MODE_PHASE: shifted = prod_reg >> SH_PH;
            default:    shifted = prod_reg >> SH_LIN;
        endcase
    end

    assign pixel = pixel_reg;

endmodule

/* design/complex_to_display_pixel.sv */
// Top level: complex sample to 8-bit display pixel with optional fftshift placement.
// Depends on c2dp_pkg, c2dp_sqrt, c2dp_cordic, c2dp_scale.
//
// Usage:
//   in_valid/in_ready/in_data carry one complex sample (Q16.16) with its row
//   and column per transaction; out_valid/out_ready/out_data return one pixel
//   with its destination row and column per input transaction, in order.
//   cfg_wr_en/cfg_addr/cfg_wr_data write a register; write only
//   while no transaction is in flight.
// Throughput and pipeline:
//   One transaction per clock while the skid register is empty. A sample passes
//   through 38 register stages (input register, two for the squares, 32
//   square-root steps, which the 30-step CORDIC is padded to match, three for
//   gain scaling) and then the output register.
// Reset:
//   Clears the pipeline, output and skid valid bits, and loads the
//   configuration defaults (squared magnitude, no shift, unit gain, 4096x4096).
// Backpressure:
//   When out_ready is low the output register holds; the next result lands in
//   a skid register and only then does the pipeline freeze and in_ready drop.
//   in_ready comes from a register, never from out_ready.
module complex_to_display_pixel (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  c2dp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output c2dp_pkg::out_item_t out_data,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [23:0]         cfg_wr_data
);
    import c2dp_pkg::*;

    localparam int LAST = PIPE_DEPTH - 1;
    localparam int DLY  = SQRT_STEPS;

    // configuration
    logic [2:0]  mode_reg;
    logic        fshift_reg;
    logic [23:0] gain_reg;
    logic [12:0] rows_reg;
    logic [12:0] cols_reg;

    // pipeline control and placement
    logic        en;
    logic        valid_reg [PIPE_DEPTH];
    logic [11:0] row_reg   [PIPE_DEPTH];
    logic [11:0] col_reg   [PIPE_DEPTH];

    // value path
    logic signed [31:0] re0_reg;
    logic signed [31:0] im0_reg;
    logic [31:0]        are0_reg;
    logic [31:0]        aim0_reg;
    logic [63:0]        sqa1_reg;
    logic [63:0]        sqb1_reg;
    logic [31:0]        lin1_reg;
    logic [63:0]        dir2_reg;
    logic [63:0]        dir_dly_reg [DLY];
    logic [31:0]        ph_dly_reg  [2];
    logic [31:0]        root;
    logic [31:0]        phase_mag;
    logic [63:0]        mag;
    logic [7:0]         pixel;

    // output side
    logic      out_v_reg;
    logic      out_v_next;
    logic      skid_v_reg;
    logic      skid_v_next;
    out_item_t out_data_reg;
    out_item_t skid_data_reg;
    out_item_t pipe_item;
    logic      pipe_take;
    logic      load_out_pipe;
    logic      load_out_skid;
    logic      load_skid;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SQ;
            fshift_reg <= 1'b0;
            gain_reg   <= 24'd65536;
            rows_reg   <= 13'd4096;
            cols_reg   <= 13'd4096;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_MODE:  mode_reg   <= cfg_wr_data[2:0];
                CFG_SHIFT: fshift_reg <= cfg_wr_data[0];
                CFG_GAIN:  gain_reg   <= cfg_wr_data;
                CFG_ROWS:  rows_reg   <= cfg_wr_data[12:0];
                CFG_COLS:  cols_reg   <= cfg_wr_data[12:0];
                default:   ;
            endcase
        end
    end

    // whole pipeline moves together; frozen only while the skid is occupied
    assign en       = !skid_v_reg;
    assign in_ready = en;

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // ---------------- destination indices ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg[0] <= place(in_data.in_row, rows_reg, fshift_reg);
            col_reg[0] <= place(in_data.in_col, cols_reg, fshift_reg);
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                row_reg[i] <= row_reg[i-1];
                col_reg[i] <= col_reg[i-1];
            end
        end
    end

    // ---------------- front end: abs, squares, direct value ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re0_reg  <= in_data.real_part;
            im0_reg  <= in_data.imag_part;
            are0_reg <= in_data.real_part[31] ? (~in_data.real_part + 32'd1)
                                               : in_data.real_part;
            aim0_reg <= in_data.imag_part[31] ? (~in_data.imag_part + 32'd1)
                                               : in_data.imag_part;

            sqa1_reg <= 64'(are0_reg) * 64'(are0_reg);
            sqb1_reg <= 64'(aim0_reg) * 64'(aim0_reg);
            lin1_reg <= (mode_reg == MODE_IM) ? aim0_reg : are0_reg;

            dir_dly_reg[0] <= dir2_reg;
            for (int i = 1; i < DLY; i++)
                dir_dly_reg[i] <= dir_dly_reg[i-1];

            ph_dly_reg[0] <= phase_mag;
            ph_dly_reg[1] <= ph_dly_reg[0];
        end
    end

    // squared magnitude feeds both its own mode and the square root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (mode_reg) inside
                MODE_SQ, MODE_MAG: dir2_reg <= sqa1_reg + sqb1_reg;
                default:           dir2_reg <= {32'd0, lin1_reg};
            endcase
        end
    end

    c2dp_sqrt u_sqrt (
        .clk   (clk),
        .en    (en),
        .value (dir2_reg),
        .root  (root)
    );

    c2dp_cordic u_cordic (
        .clk       (clk),
        .en        (en),
        .re        (re0_reg),
        .im        (im0_reg),
        .phase_mag (phase_mag)
    );

    // all three paths line up here
    always_comb
    begin
        unique case (mode_reg)
            MODE_MAG:   mag = {32'd0, root};
            MODE_PHASE: mag = {32'd0, ph_dly_reg[1]};
            default:    mag = dir_dly_reg[DLY-1];
        endcase
    end

    c2dp_scale u_scale (
        .clk   (clk),
        .en    (en),
        .mode  (mode_reg),
        .gain  (gain_reg),
        .mag   (mag),
        .pixel (pixel)
    );

    // ---------------- output register and skid ----------------
    assign pipe_item.pixel_value = pixel;
    assign pipe_item.out_row     = row_reg[LAST];
    assign pipe_item.out_col     = col_reg[LAST];

    assign pipe_take     = en && valid_reg[LAST];
    assign load_out_pipe = pipe_take && (!out_v_reg || out_ready);
    assign load_skid     = pipe_take && out_v_reg && !out_ready;
    assign load_out_skid = skid_v_reg && out_ready;

    always_comb
    begin
        out_v_next = out_v_reg;
        if (load_out_pipe || load_out_skid)
            out_v_next = 1'b1;
        else if (out_ready)
            out_v_next = 1'b0;

        skid_v_next = skid_v_reg;
        if (load_skid)
            skid_v_next = 1'b1;
        else if (load_out_skid)
            skid_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_skid)
            out_data_reg <= skid_data_reg;
        else if (load_out_pipe)
            out_data_reg <= pipe_item;

        if (load_skid)
            skid_data_reg <= pipe_item;
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_data_reg;

endmodule

/* design/c2dp_checker.sv */
// Port-level checks for complex_to_display_pixel, bound to the top level.
// Depends on c2dp_pkg.
module c2dp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input c2dp_pkg::out_item_t out_data
);
    import c2dp_pkg::*;

    localparam int CAPACITY = PIPE_DEPTH + 2;

    logic [5:0] pend_reg;
    logic [5:0] pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_valid && in_ready)
            pend_next = pend_next + 6'd1;
        if (out_valid && out_ready)
            pend_next = pend_next - 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // no result without an accepted transaction behind it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 6'd0)
        else $error("result without pending transaction");

    // in-flight count bounded by stages plus output and skid
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 6'(CAPACITY))
        else $error("more transactions in flight than storage");

    // input blocked only while a result waits downstream
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with no result waiting");

endmodule

bind complex_to_display_pixel c2dp_checker u_c2dp_checker (.*);

/* dv/complex_to_display_pixel_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for complex_to_display_pixel: tracks register writes, predicts each pixel
// and destination index, and compares output transactions in order. Depends on c2dp_pkg.
module complex_to_display_pixel_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  c2dp_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  c2dp_pkg::out_item_t out_data,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [23:0]         cfg_wr_data,
    output int                  mismatch_count,
    output int                  pixels_pending,
    output int                  pixels_checked
);
    import c2dp_pkg::*;

    logic [2:0]  mode_q;
    logic        shift_q;
    logic [23:0] gain_q;
    logic [12:0] rows_q;
    logic [12:0] cols_q;

    out_item_t pixel_fifo[$];

    function automatic logic [7:0] scale_pixel(logic [63:0] mag, int sh, logic [23:0] gain);
        logic [127:0] p;
        p = {64'd0, mag} * (128'd255 * {104'd0, gain});
        p = p >> sh;
        return (p > 128'd255) ? 8'd255 : p[7:0];
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] one;
        res = 64'd0;
        one = 64'h4000_0000_0000_0000;
        while (one > v)
            one = one >> 2;
        while (one != 0)
        begin
            if (v >= res + one)
            begin
                v   = v - (res + one);
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one = one >> 2;
        end
        return res;
    endfunction

    // atan(2^-i) in 2^-32 turn
    function automatic logic [31:0] atan_turn(int i);
        logic [31:0] t [30] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
        return t[i];
    endfunction

    function automatic logic [31:0] phase_angle(longint re, longint im);
        longint x, y, dx, dy;
        logic [31:0] ang;
        ang = 32'd0;
        x = re;
        y = im;
        if (re == 0 && im == 0)
            return 32'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            ang = 32'h8000_0000;
        end
        x = x * (64'sd1 <<< 30);
        y = y * (64'sd1 <<< 30);
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                ang = ang + atan_turn(i);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                ang = ang - atan_turn(i);
            end
        end
        return ang;
    endfunction

    function automatic logic [11:0] swap_index(logic [11:0] idx, logic [12:0] size, logic sw);
        logic [12:0] n;
        logic [12:0] half;
        logic [12:0] r;
        n    = (size > 13'd4096) ? 13'd4096 : size;
        half = n >> 1;
        r    = {1'b0, idx};
        if (sw)
            r = (r < half) ? r + half : r - half;
        return r[11:0];
    endfunction

    function automatic out_item_t predict_pixel(in_item_t s);
        out_item_t o;
        longint re, im;
        logic [63:0] are, aim, sq, m;
        logic [31:0] a;
        re  = longint'(s.real_part);
        im  = longint'(s.imag_part);
        are = (re < 0) ? 64'(-re) : 64'(re);
        aim = (im < 0) ? 64'(-im) : 64'(im);
        sq  = are * are + aim * aim;
        case (mode_q)
            MODE_SQ:  o.pixel_value = scale_pixel(sq, SH_SQ, gain_q);
            MODE_MAG: o.pixel_value = scale_pixel(root_floor(sq), SH_LIN, gain_q);
            MODE_IM:  o.pixel_value = scale_pixel(aim, SH_LIN, gain_q);
            MODE_PHASE:
            begin
                a = phase_angle(re, im);
                m = a[31] ? (64'h1_0000_0000 - {32'd0, a}) : {32'd0, a};
                o.pixel_value = scale_pixel(m, SH_PH, gain_q);
            end
            default:  o.pixel_value = scale_pixel(are, SH_LIN, gain_q);  // real, undefined modes
        endcase
        o.out_row = swap_index(s.in_row, rows_q, shift_q);
        o.out_col = swap_index(s.in_col, cols_q, shift_q);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            mode_q  <= MODE_SQ;
            shift_q <= 1'b0;
            gain_q  <= 24'd65536;
            rows_q  <= 13'd4096;
            cols_q  <= 13'd4096;
            pixel_fifo.delete();
            mismatch_count <= 0;
            pixels_pending <= 0;
            pixels_checked <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_MODE:  mode_q  <= cfg_wr_data[2:0];
                    CFG_SHIFT: shift_q <= cfg_wr_data[0];
                    CFG_GAIN:  gain_q  <= cfg_wr_data;
                    CFG_ROWS:  rows_q  <= cfg_wr_data[12:0];
                    CFG_COLS:  cols_q  <= cfg_wr_data[12:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                pixel_fifo.push_back(predict_pixel(in_data));
            if (out_valid && out_ready)
            begin
                pixels_checked <= pixels_checked + 1;
                if (pixel_fifo.size() == 0)
                begin
                    $error("unexpected pixel transaction %p", out_data);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    e = pixel_fifo.pop_front();
                    if (e != out_data)
                        mismatch_count <= mismatch_count + 1;
                    if (e.pixel_value != out_data.pixel_value)
                        $error("pixel_value expected %0d actual %0d",
                               e.pixel_value, out_data.pixel_value);
                    if (e.out_row != out_data.out_row)
                        $error("out_row expected %0d actual %0d", e.out_row, out_data.out_row);
                    if (e.out_col != out_data.out_col)
                        $error("out_col expected %0d actual %0d", e.out_col, out_data.out_col);
                end
            end
            pixels_pending <= pixel_fifo.size();
        end
    end

endmodule

/* dv/complex_to_display_pixel_test.sv */
`timescale 1ns / 100ps
// Testbench top: clock, reset, register phases, bursty sample stimulus. Depends
// on c2dp_pkg, complex_to_display_pixel and complex_to_display_pixel_checker.
module complex_to_display_pixel_test;
    import c2dp_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_wr_en;
    logic [2:0] cfg_addr;
    logic [23:0] cfg_wr_data;

    int mismatch_count;
    int pixels_pending;
    int pixels_checked;
    int burst_left;
    int samples_sent;
    int cycle_count;

    complex_to_display_pixel uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    complex_to_display_pixel_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .mismatch_count(mismatch_count), .pixels_pending(pixels_pending),
        .pixels_checked(pixels_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: far above the slowest legal run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("complex_to_display_pixel_test: done, errors");
                $finish;
            end
        end
    end

    // Receiver backpressure: switches at random between free-flowing, random,
    // heavy-stall and periodic patterns, so stalls land on every pipeline phase.
    initial
    begin
        int pat;
        int left;
        out_ready = 1'b0;
        pat = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                pat  = $urandom_range(0, 3);
                left = $urandom_range(5, 80);
            end
            left--;
            case (pat)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (left % 3 != 0);
            endcase
        end
    end

    // One register write; the enable stays high so writes can follow back to
    // back, and the caller drops it after the last one
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
    endtask

    // Present one sample and hold it until the transaction completes. Between
    // bursts the valid line drops for a random gap.
    task automatic send_sample(in_item_t s);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent++;
    endtask

    // Stop sending and wait out the pipeline so registers can change safely
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pixels_pending != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);
    endtask

    task automatic set_config(logic [2:0] mode, logic sw, logic [23:0] gain,
                              logic [12:0] rows, logic [12:0] cols);
        write_reg(CFG_MODE, {21'd0, mode});
        write_reg(CFG_SHIFT, {23'd0, sw});
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_ROWS, {11'd0, rows});
        write_reg(CFG_COLS, {11'd0, cols});
        cfg_wr_en <= 1'b0;
    endtask

    // Q16.16 component: full range now and then, mostly scaled down so the
    // pixel lands below saturation
    function automatic logic signed [31:0] rand_component();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 4) != 0)
            v = v >> $urandom_range(8, 31);
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    function automatic logic [12:0] rand_size();
        case ($urandom_range(0, 5))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'd4096;
            3: return 13'(8191 - $urandom_range(0, 4000));  // clamped to max
            default: return 13'($urandom_range(2, 4096));
        endcase
    endfunction

    function automatic logic [23:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'd65536;
            3: return 24'($urandom_range(1, 300));
            default: return 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12));
        endcase
    endfunction

    initial
    begin
        in_item_t edge_cases [8];
        in_item_t s;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= CFG_MODE;
        cfg_wr_data <= '0;
        burst_left  = 0;
        samples_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, zero sample, negative real axis, and index corners
        edge_cases[0] = '{32'sd0, 32'sd0, 12'd0, 12'd0};
        edge_cases[1] = '{32'h7FFFFFFF, 32'h7FFFFFFF, 12'd4095, 12'd4095};
        edge_cases[2] = '{32'h80000000, 32'h80000000, 12'd2047, 12'd2048};
        edge_cases[3] = '{-32'sd65536, 32'sd0, 12'd2048, 12'd2047};
        edge_cases[4] = '{32'sd0, 32'sd65536, 12'd1, 12'd4094};
        edge_cases[5] = '{32'sd46341, -32'sd46341, 12'hAAA, 12'h555};
        edge_cases[6] = '{-32'sd1, 32'sd1, 12'h555, 12'hAAA};
        edge_cases[7] = '{32'sd65536, -32'sd1, 12'd100, 12'd3000};

        // Reset defaults first, then phase mode with the half-frame swap
        foreach (edge_cases[i])
            send_sample(edge_cases[i]);
        drain_pipeline();
        set_config(MODE_PHASE, 1'b1, 24'd65536, 13'd4096, 13'd4096);
        foreach (edge_cases[i])
            send_sample(edge_cases[i]);
        drain_pipeline();

        // Random phases; the first few walk through every mode
        for (int ph = 0; ph < 12; ph++)
        begin
            set_config((ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7)),
                       ph[0] | ($urandom_range(0, 1) == 1), rand_gain(),
                       rand_size(), rand_size());
            for (int k = 0; k < 82; k++)
            begin
                s.real_part = rand_component();
                s.imag_part = rand_component();
                s.in_row    = 12'($urandom_range(0, 4095));
                s.in_col    = 12'($urandom_range(0, 4095));
                send_sample(s);
                // one full stop in the middle of a phase
                if (ph == 3 && k == 40)
                    drain_pipeline();
            end
            drain_pipeline();
        end

        $display("Covered %0d samples over all display modes, swap on and off,", samples_sent);
        $display("gain and frame sizes at their limits; %0d pixels compared.", pixels_checked);
        if (mismatch_count == 0 && pixels_pending == 0)
            $display("complex_to_display_pixel_test: done, clean");
        else
            $display("complex_to_display_pixel_test: done, errors");
        $finish;
    end

endmodule
